/* design/uvs_pkg.sv */
`default_nettype none

package uvs_pkg;

    typedef enum logic [2:0] {
        PH_TOP,
        PH_RING,
        PH_CAP,
        PH_BAND,
        PH_BOTTOM,
        PH_BOTTRI,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_TRIG,
        SQ_MUL1,
        SQ_MUL2,
        SQ_WRITE
    } seq_state_t;

    typedef struct packed {
        logic        rd_en;
        logic [15:0] angle;
    } trig_req_t;

    localparam logic [2:0] CFG_RADIUS        = 3'd0;
    localparam logic [2:0] CFG_RING_COUNT    = 3'd1;
    localparam logic [2:0] CFG_SEGMENT_COUNT = 3'd2;
    localparam logic [2:0] CFG_POLAR_STEP    = 3'd3;
    localparam logic [2:0] CFG_AZIMUTH_STEP  = 3'd4;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_TRI    = 1'b1;

    localparam logic [15:0] ANGLE_0   = 16'd0;
    localparam logic [15:0] ANGLE_90  = 16'd16384;
    localparam logic [15:0] ANGLE_180 = 16'd32768;

    localparam logic [2:0] TRIG_READS = 3'd4;

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [63:0] SERIES_DIV [10] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
        64'd156, 64'd210, 64'd272, 64'd342, 64'd420
    };

    // round half away from zero, then saturate to 16 bits
    function automatic logic signed [15:0] round_sat(input logic signed [49:0] p,
                                                     input int unsigned sh);
        logic        [49:0] mag;
        logic        [49:0] half;
        logic        [49:0] rq;
        logic signed [50:0] v;
        half = 50'd1 << (sh - 1);
        mag  = (p < 0) ? 50'(-p) : 50'(p);
        rq   = (mag + half) >> sh;
        v    = (p < 0) ? -$signed({1'b0, rq}) : $signed({1'b0, rq});
        if (v > 51'sd32767) begin
            v = 51'sd32767;
        end else if (v < -51'sd32768) begin
            v = -51'sd32768;
        end
        return 16'(v);
    endfunction

endpackage

`default_nettype wire

/* design/uvs_trig.sv */
`default_nettype none

module uvs_trig
    import uvs_pkg::*;
#(
    parameter int TRIG_TABLE_DEPTH = 256
) (
    input  wire logic               aclk,
    input  wire trig_req_t          req,
    output logic signed [15:0]      value
);

    localparam int AW = $clog2(TRIG_TABLE_DEPTH + 1);
    localparam int PW = 15 + AW;

    typedef logic [TRIG_TABLE_DEPTH:0][14:0] rom_t;

    function automatic rom_t build_rom();
        rom_t               t;
        logic        [63:0] x;
        logic        [63:0] x2;
        logic        [63:0] term;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        for (int k = 0; k <= TRIG_TABLE_DEPTH; k++) begin
            x    = (PI_HALF_Q30 * 64'(k)) / 64'(TRIG_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (int n = 1; n <= 10; n++) begin
                term = ((term * x2) >> 30) / SERIES_DIV[n - 1];
                if (n[0]) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 64'sd0;
            end
            v = (sum * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
            if (v > 64'sd32767) begin
                v = 64'sd32767;
            end
            t[k] = 15'(v);
        end
        return t;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [1:0]    quad;
    logic [13:0]   frac;
    logic [14:0]   fold;
    logic [PW-1:0] scaled;
    logic [AW-1:0] addr;
    logic [14:0]   tab_reg;
    logic          neg_reg;

    assign quad   = req.angle[15:14];
    assign frac   = req.angle[13:0];
    assign fold   = quad[0] ? (15'd16384 - {1'b0, frac}) : {1'b0, frac};
    assign scaled = PW'(fold) * PW'(TRIG_TABLE_DEPTH);
    assign addr   = AW'(scaled >> 14);

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            tab_reg <= SINE_ROM[addr];
            neg_reg <= quad[1];
        end
    end

    assign value = neg_reg ? -$signed({1'b0, tab_reg}) : $signed({1'b0, tab_reg});

endmodule

`default_nettype wire

/* design/uv_sphere_mesh_generator.sv */
`default_nettype none

// A triangle item goes straight to SQ_WRITE; a vertex item via SQ_TRIG, SQ_MUL1 and SQ_MUL2.
// One item at a time: the next is taken only once the last is loaded, after any output stall.
// Vertex time is set by four sequential reads of the single-port sine table and two multiplies.
// Reset (aresetn low, synchronous): config, walk, sequencer and output-valid registers return
// to defaults, the walk restarts at the top pole; the sine table is constant and needs no fill.
module uv_sphere_mesh_generator
    import uvs_pkg::*;
#(
    parameter int TRIG_TABLE_DEPTH = 256,
    parameter int INDEX_BITS       = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [0] restart, [7:1] zero
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [15:0] pos_x, [31:16] pos_y, [47:32] pos_z, [63:48] norm_x, [79:64] norm_y,
    // [95:80] norm_z, [111:96] corner_a, [127:112] corner_b, [143:128] corner_c
    output logic [143:0]      m_tdata,
    output logic              m_tuser,   // [0] kind
    output logic              m_tlast
);

    localparam int IB = INDEX_BITS;

    logic [15:0] radius_reg;
    logic [7:0]  ring_count_reg;
    logic [7:0]  segment_count_reg;
    logic [14:0] polar_step_reg;
    logic [14:0] azimuth_step_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  ring_index_reg, ring_index_next;
    logic [7:0]  seg_reg, seg_next;
    logic        second_half_reg, second_half_next;
    logic [IB-1:0] ring_base_reg, ring_base_next;
    logic [15:0] polar_reg, polar_next;
    logic [15:0] azimuth_reg, azimuth_next;

    seq_state_t  state_reg, state_next;
    logic [2:0]  trig_cnt_reg;

    logic          kind_reg, kind_next;
    logic          last_reg, last_next;
    logic [IB-1:0] ca_reg, ca_next;
    logic [IB-1:0] cb_reg, cb_next;
    logic [IB-1:0] cc_reg, cc_next;
    logic [15:0]   vang_reg, vang_next;
    logic [15:0]   hang_reg, hang_next;

    logic signed [15:0] sv_reg, cv_reg, sh_reg, ch_reg;
    logic signed [31:0] cs_reg, ss_reg;
    logic signed [32:0] ry_reg;
    logic signed [48:0] px_reg, pz_reg;

    logic        m_tvalid_reg;
    logic [143:0] m_tdata_reg;
    logic        m_tuser_reg;
    logic        m_tlast_reg;

    logic        in_accept;
    logic        out_free;
    logic        load_out;
    trig_req_t   trig_req;
    logic signed [15:0] trig_value;

    // walker signals
    phase_t      phase_eff;
    logic [7:0]  r_eff, s_eff;
    logic [8:0]  seg_inc, ring_inc;
    logic        seg_end;
    logic [7:0]  nxt;
    logic [IB-1:0] s_ix, cur_ix, nv_ix;
    logic signed [16:0] radius_s;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg        <= 16'd256;
            ring_count_reg    <= 8'd8;
            segment_count_reg <= 8'd8;
            polar_step_reg    <= 15'd4096;
            azimuth_step_reg  <= 15'd8192;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_RADIUS:        radius_reg        <= cfg_data;
                CFG_RING_COUNT:    ring_count_reg    <= cfg_data[7:0];
                CFG_SEGMENT_COUNT: segment_count_reg <= cfg_data[7:0];
                CFG_POLAR_STEP:    polar_step_reg    <= cfg_data[14:0];
                CFG_AZIMUTH_STEP:  azimuth_step_reg  <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign r_eff    = (ring_count_reg < 8'd2) ? 8'd2 : ring_count_reg;
    assign s_eff    = (segment_count_reg < 8'd3) ? 8'd3 : segment_count_reg;
    assign phase_eff = s_tdata[0] ? PH_TOP : phase_reg;
    assign seg_inc  = {1'b0, seg_reg} + 9'd1;
    assign ring_inc = {1'b0, ring_index_reg} + 9'd1;
    assign seg_end  = seg_inc >= {1'b0, s_eff};
    assign nxt      = seg_end ? 8'd0 : seg_inc[7:0];
    assign s_ix     = IB'(s_eff);
    assign cur_ix   = ring_base_reg + IB'(seg_reg);
    assign nv_ix    = ring_base_reg + IB'(nxt);

    // mesh walk: one element per accepted item
    always_comb begin
        phase_next       = phase_reg;
        ring_index_next  = ring_index_reg;
        seg_next         = seg_reg;
        second_half_next = second_half_reg;
        ring_base_next   = ring_base_reg;
        polar_next       = polar_reg;
        azimuth_next     = azimuth_reg;
        kind_next        = KIND_TRI;
        last_next        = 1'b0;
        ca_next          = '0;
        cb_next          = '0;
        cc_next          = '0;
        vang_next        = ANGLE_0;
        hang_next        = ANGLE_0;
        unique case (phase_eff)
            PH_TOP: begin
                kind_next        = KIND_VERTEX;
                phase_next       = PH_RING;
                ring_index_next  = 8'd1;
                seg_next         = 8'd0;
                second_half_next = 1'b0;
                ring_base_next   = IB'(1);
                polar_next       = {1'b0, polar_step_reg};
                azimuth_next     = ANGLE_0;
            end
            PH_RING: begin
                kind_next    = KIND_VERTEX;
                vang_next    = polar_reg;
                hang_next    = azimuth_reg;
                azimuth_next = azimuth_reg + {1'b0, azimuth_step_reg};
                seg_next     = seg_inc[7:0];
                if (seg_end) begin
                    seg_next         = 8'd0;
                    azimuth_next     = ANGLE_0;
                    second_half_next = 1'b0;
                    phase_next       = (ring_index_reg <= 8'd1) ? PH_CAP : PH_BAND;
                end
            end
            PH_CAP, PH_BAND: begin
                if (phase_eff == PH_CAP) begin
                    ca_next  = IB'(1) + IB'(seg_reg);
                    cb_next  = IB'(1) + IB'(nxt);
                    cc_next  = '0;
                    seg_next = seg_inc[7:0];
                end else if (!second_half_reg) begin
                    ca_next          = cur_ix;
                    cb_next          = nv_ix;
                    cc_next          = cur_ix - s_ix;
                    second_half_next = 1'b1;
                end else begin
                    ca_next          = nv_ix;
                    cb_next          = nv_ix - s_ix;
                    cc_next          = cur_ix - s_ix;
                    second_half_next = 1'b0;
                    seg_next         = seg_inc[7:0];
                end
                if (seg_end && (phase_eff == PH_CAP || second_half_reg)) begin
                    seg_next         = 8'd0;
                    second_half_next = 1'b0;
                    azimuth_next     = ANGLE_0;
                    if (ring_inc < {1'b0, r_eff}) begin
                        ring_index_next = ring_inc[7:0];
                        ring_base_next  = ring_base_reg + s_ix;
                        polar_next      = polar_reg + {1'b0, polar_step_reg};
                        phase_next      = PH_RING;
                    end else begin
                        phase_next = PH_BOTTOM;
                    end
                end
            end
            PH_BOTTOM: begin
                kind_next  = KIND_VERTEX;
                vang_next  = ANGLE_180;
                phase_next = PH_BOTTRI;
                seg_next   = 8'd0;
            end
            PH_BOTTRI: begin
                ca_next = cur_ix;
                cb_next = ring_base_reg + s_ix;
                cc_next = nv_ix;
                if (seg_end) begin
                    last_next  = 1'b1;
                    phase_next = PH_DONE;
                end else begin
                    seg_next = seg_inc[7:0];
                end
            end
            default: begin
                ca_next   = ring_base_reg + s_ix - IB'(1);
                cb_next   = ring_base_reg + s_ix;
                cc_next   = ring_base_reg;
                last_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_TOP;
            ring_index_reg  <= 8'd0;
            seg_reg         <= 8'd0;
            second_half_reg <= 1'b0;
            ring_base_reg   <= IB'(1);
            polar_reg       <= ANGLE_0;
            azimuth_reg     <= ANGLE_0;
        end else if (in_accept) begin
            phase_reg       <= phase_next;
            ring_index_reg  <= ring_index_next;
            seg_reg         <= seg_next;
            second_half_reg <= second_half_next;
            ring_base_reg   <= ring_base_next;
            polar_reg       <= polar_next;
            azimuth_reg     <= azimuth_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            kind_reg <= kind_next;
            last_reg <= last_next;
            ca_reg   <= ca_next;
            cb_reg   <= cb_next;
            cc_reg   <= cc_next;
            vang_reg <= vang_next;
            hang_reg <= hang_next;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SQ_IDLE: begin
                if (in_accept) begin
                    state_next = (kind_next == KIND_VERTEX) ? SQ_TRIG : SQ_WRITE;
                end
            end
            SQ_TRIG:  state_next = (trig_cnt_reg == TRIG_READS) ? SQ_MUL1 : SQ_TRIG;
            SQ_MUL1:  state_next = SQ_MUL2;
            SQ_MUL2:  state_next = SQ_WRITE;
            SQ_WRITE: state_next = out_free ? SQ_IDLE : SQ_WRITE;
            default:  state_next = SQ_IDLE;
        endcase
    end

    always_comb begin
        s_tready       = 1'b0;
        load_out       = 1'b0;
        trig_req.rd_en = 1'b0;
        trig_req.angle = vang_reg;
        unique case (state_reg)
            SQ_IDLE:  s_tready = aresetn;
            SQ_TRIG: begin
                trig_req.rd_en = trig_cnt_reg < TRIG_READS;
                case (trig_cnt_reg)
                    3'd1:    trig_req.angle = vang_reg + ANGLE_90;
                    3'd2:    trig_req.angle = hang_reg;
                    3'd3:    trig_req.angle = hang_reg + ANGLE_90;
                    default: trig_req.angle = vang_reg;
                endcase
            end
            SQ_WRITE: load_out = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= SQ_IDLE;
            trig_cnt_reg <= 3'd0;
        end else begin
            state_reg    <= state_next;
            trig_cnt_reg <= (state_reg == SQ_TRIG) ? trig_cnt_reg + 3'd1 : 3'd0;
        end
    end

    uvs_trig #(
        .TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)
    ) u_trig (
        .aclk  (aclk),
        .req   (trig_req),
        .value (trig_value)
    );

    assign radius_s = $signed({1'b0, radius_reg});

    // capture trig terms, then two multiply stages
    always_ff @(posedge aclk) begin
        if (state_reg == SQ_TRIG) begin
            case (trig_cnt_reg)
                3'd1:    sv_reg <= trig_value;
                3'd2:    cv_reg <= trig_value;
                3'd3:    sh_reg <= trig_value;
                3'd4:    ch_reg <= trig_value;
                default: ;
            endcase
        end
        if (state_reg == SQ_MUL1) begin
            cs_reg <= ch_reg * sv_reg;
            ss_reg <= sh_reg * sv_reg;
            ry_reg <= radius_s * cv_reg;
        end
        if (state_reg == SQ_MUL2) begin
            px_reg <= radius_s * cs_reg;
            pz_reg <= radius_s * ss_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tuser_reg <= kind_reg;
            if (kind_reg == KIND_VERTEX) begin
                m_tlast_reg <= 1'b0;
                m_tdata_reg <= {
                    48'd0,
                    round_sat(-50'(ss_reg), 15),
                    cv_reg,
                    round_sat(50'(cs_reg), 15),
                    round_sat(-50'(pz_reg), 30),
                    round_sat(50'(ry_reg), 15),
                    round_sat(50'(px_reg), 30)
                };
            end else begin
                m_tlast_reg <= last_reg;
                m_tdata_reg <= {16'(cc_reg), 16'(cb_reg), 16'(ca_reg), 96'd0};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> state_reg != SQ_IDLE)
        else $error("accepted item did not start work");

    a_last_is_triangle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == KIND_TRI)
        else $error("last flag on a vertex item");

    a_trig_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == SQ_TRIG |-> trig_cnt_reg <= TRIG_READS)
        else $error("trig read counter overran");

    a_write_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == SQ_WRITE && m_tvalid && !m_tready |=> state_reg == SQ_WRITE)
        else $error("result dropped while output stalled");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != SQ_IDLE |-> !s_tready)
        else $error("item taken while busy");

endmodule

`default_nettype wire
